// ===== hdl/stk_pkg.sv =====
// ----------------------------------------------------------------------------
// stk_pkg
// Shared widths, operation and status codes for the middle-access stack.
// ----------------------------------------------------------------------------
package stk_pkg;

  localparam int DATA_W        = 32;
  localparam int OP_W          = 2;
  localparam int ST_W          = 2;
  localparam int DEFAULT_DEPTH = 256;

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [ST_W-1:0]   status_t;
  typedef logic [DATA_W-1:0] word_t;

  localparam op_t OP_PUSH       = 2'd0;
  localparam op_t OP_POP        = 2'd1;
  localparam op_t OP_READ_MID   = 2'd2;
  localparam op_t OP_DELETE_MID = 2'd3;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

endpackage

// ===== hdl/stk_if.sv =====
// ----------------------------------------------------------------------------
// stk_if
// Ready/valid channels for the stack: request words in, result words out.
// ----------------------------------------------------------------------------
interface stk_in_if
  import stk_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic        [OP_W-1:0]   operation;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, output operation, output push_value, input ready);
  modport sink   (input valid, input operation, input push_value, output ready);
endinterface

interface stk_out_if
  import stk_pkg::*;
#(
  parameter int CNT_W = 9
) ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] out_value;
  logic        [ST_W-1:0]   status;
  logic        [CNT_W-1:0]  element_total;

  modport source (output valid, output out_value, output status, output element_total,
                  input ready);
  modport sink   (input valid, input out_value, input status, input element_total,
                  output ready);
endinterface

// ===== hdl/stk_mem.sv =====
// ----------------------------------------------------------------------------
// stk_mem
// Stack storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module stk_mem
  import stk_pkg::*;
#(
  parameter int STACK_DEPTH = DEFAULT_DEPTH,
  parameter int ADDR_W      = $clog2(STACK_DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  word_t             wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output word_t             rd_data
);

  word_t mem [STACK_DEPTH];
  word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold the last read word until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/stack_with_middle_access.sv =====
// ----------------------------------------------------------------------------
// stack_with_middle_access
// Bounded stack of signed words with read and delete of the middle element.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  carries one request word: operation (push, pop, read middle,
//          delete middle) and push_value. in_if.ready is high whenever the
//          sequencer is idle; requests are served one at a time.
//   out_if returns exactly one result word per request: out_value, status
//          (ok, empty, full) and element_total, the count after the request.
//   The middle is the entry at index count/2 counted from the bottom.
// Sequencer steps per request:
//   push, or any request refused as full/empty: S_IDLE, then S_OUT;
//   pop and read middle: S_IDLE, S_RD, S_OUT (one synchronous store read);
//   delete middle: S_IDLE, S_RD, S_SHIFT while entries above the middle
//   remain, moving them down one per cycle, since the single read port and
//   single write port of the store each carry one access a cycle; then S_OUT.
//   out_if.valid is registered: it rises after S_OUT hands over the result.
// Reset clears the count, the sequencer state and out_if.valid; the store
//   itself is not cleared, since no entry at or above the count is ever read.
// A stalled receiver holds the result in the output register; a new request
//   is still taken and worked on, and waits at its final step until the
//   previous word has left.
// ----------------------------------------------------------------------------
module stack_with_middle_access
  import stk_pkg::*;
#(
  parameter int STACK_DEPTH = DEFAULT_DEPTH,
  parameter int ADDR_W      = $clog2(STACK_DEPTH),
  parameter int CNT_W       = $clog2(STACK_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  stk_in_if.sink            in_if,
  stk_out_if.source         out_if
);

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;  // take a request
  localparam logic [1:0] S_RD    = 2'd1;  // read word arriving
  localparam logic [1:0] S_SHIFT = 2'd2;  // move upper entries down
  localparam logic [1:0] S_OUT   = 2'd3;  // hand result to output register

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  op_t               op_r, op_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;
  word_t             res_val_r, res_val_nxt;
  status_t           res_st_r, res_st_nxt;

  logic              out_valid_r, out_valid_nxt;
  word_t             out_val_r, out_val_nxt;
  status_t           out_st_r, out_st_nxt;
  logic [CNT_W-1:0]  out_cnt_r, out_cnt_nxt;

  // store port signals
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  word_t             mem_wd;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_ra;
  word_t             mem_rd;

  logic              in_acc;
  logic [CNT_W-1:0]  cnt_dec;
  logic [CNT_W-1:0]  cnt_mid;
  logic [CNT_W-1:0]  ptr_ext;
  logic [CNT_W-1:0]  ptr_inc1;
  logic [CNT_W-1:0]  ptr_inc2;
  logic              out_free;

  assign in_if.ready = (state_r == S_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign cnt_dec     = cnt_r - CNT_W'(1);
  assign cnt_mid     = cnt_r >> 1;
  assign ptr_ext     = CNT_W'(ptr_r);
  assign ptr_inc1    = ptr_ext + CNT_W'(1);
  assign ptr_inc2    = ptr_ext + CNT_W'(2);
  assign out_free    = !out_valid_r || out_if.ready;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    op_nxt      = op_r;
    ptr_nxt     = ptr_r;
    res_val_nxt = res_val_r;
    res_st_nxt  = res_st_r;
    mem_we      = 1'b0;
    mem_wa      = cnt_r[ADDR_W-1:0];
    mem_wd      = in_if.push_value;
    mem_re      = 1'b0;
    mem_ra      = cnt_mid[ADDR_W-1:0];

    // drop the held word once taken, then load a fresh one in S_OUT
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_val_nxt   = out_val_r;
    out_st_nxt    = out_st_r;
    out_cnt_nxt   = out_cnt_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt      = in_if.operation;
          res_val_nxt = '0;
          res_st_nxt  = ST_OK;
          state_nxt   = S_OUT;
          if (in_if.operation == OP_PUSH) begin
            if (cnt_r == CNT_W'(STACK_DEPTH)) begin
              res_st_nxt = ST_FULL;
            end else begin
              // write on top, bump the count
              mem_we  = 1'b1;
              cnt_nxt = cnt_r + CNT_W'(1);
            end
          end else if (cnt_r == '0) begin
            res_st_nxt = ST_EMPTY;
          end else if (in_if.operation == OP_POP) begin
            mem_re    = 1'b1;
            mem_ra    = cnt_dec[ADDR_W-1:0];
            cnt_nxt   = cnt_dec;
            state_nxt = S_RD;
          end else begin
            // read or delete middle: fetch entry count/2
            mem_re    = 1'b1;
            ptr_nxt   = cnt_mid[ADDR_W-1:0];
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        res_val_nxt = mem_rd;
        state_nxt   = S_OUT;
        if (op_r == OP_DELETE_MID) begin
          cnt_nxt = cnt_dec;
          // entries above the middle remain: start moving them down
          if (ptr_ext < cnt_dec) begin
            mem_re    = 1'b1;
            mem_ra    = ptr_inc1[ADDR_W-1:0];
            state_nxt = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        // word from ptr+1 has arrived: write it at ptr
        mem_we = 1'b1;
        mem_wa = ptr_r;
        mem_wd = mem_rd;
        if (ptr_inc1 == cnt_r) begin
          state_nxt = S_OUT;
        end else begin
          mem_re  = 1'b1;
          mem_ra  = ptr_inc2[ADDR_W-1:0];
          ptr_nxt = ptr_inc1[ADDR_W-1:0];
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_val_r;
          out_st_nxt    = res_st_r;
          out_cnt_nxt   = cnt_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    ptr_r     <= ptr_nxt;
    res_val_r <= res_val_nxt;
    res_st_r  <= res_st_nxt;
    out_val_r <= out_val_nxt;
    out_st_r  <= out_st_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  stk_mem #(
    .STACK_DEPTH (STACK_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd),
    .rd_en   (mem_re),
    .rd_addr (mem_ra),
    .rd_data (mem_rd)
  );

  assign out_if.valid         = out_valid_r;
  assign out_if.out_value     = out_val_r;
  assign out_if.status        = out_st_r;
  assign out_if.element_total = out_cnt_r;

  // count never passes the depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STACK_DEPTH))
    else $error("element count beyond stack depth");

  // a push that fits grows the count by one
  a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_if.operation == OP_PUSH && cnt_r != CNT_W'(STACK_DEPTH))
      |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("push did not advance the count");

  // the shift pointer stays below the shrunken count
  a_shift_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT |-> ptr_ext < cnt_r)
    else $error("shift pointer outside the stack");

  // a full report only with a full stack
  a_full_st: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_st_r == ST_FULL) |-> out_cnt_r == CNT_W'(STACK_DEPTH))
    else $error("full status with room left");

  // an empty report only with an empty stack, and with a zero value
  a_empty_st: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_st_r == ST_EMPTY) |-> (out_cnt_r == '0 && out_val_r == '0))
    else $error("empty status on a non-empty stack");

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for stack_with_middle_access. Drives push, pop,
// read-middle and delete-middle requests over the ready/valid input channel,
// mirrors the stack in a local array to work out each result word, and
// compares every returned word field by field, in order.
// ----------------------------------------------------------------------------
module tb;
  import stk_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = 256;
  localparam int CNT_W        = 9;
  localparam int RANDOM_ITEMS = 900;
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int HOLD_AFTER   = 100;   // results seen before the hold-off
  localparam int STALL_LIMIT  = 3000;  // cycles with no word moving either way
  localparam int TAIL_CYCLES  = 150;   // quiet tail after the last result, for any stray word

  typedef struct packed {
    word_t              value;
    status_t            status;
    logic [CNT_W-1:0]   total;
  } result_t;

  typedef struct packed {
    op_t     op;
    word_t   value;
    logic    typed;   // 1: the row carries its own expected result
    result_t want;
  } step_t;

  typedef enum int {
    MODE_FILL,
    MODE_DRAIN,
    MODE_GROW,
    MODE_SHRINK,
    MODE_MIXED
  } mode_e;

  logic clk;
  logic rst_n;

  stk_in_if                  in_ch ();
  stk_out_if #(.CNT_W(CNT_W)) out_ch ();

  stack_with_middle_access #(
    .STACK_DEPTH(DEPTH)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  // 8 ns period
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // --------------------------------------------------------------------------
  // Mirror of the stack and the results still to come back
  // --------------------------------------------------------------------------
  word_t   mirror_words [DEPTH];
  int      mirror_count;
  result_t awaited_results [$];

  int fail_count   = 0;
  int words_sent;
  int results_seen = 0;
  int full_refusals;
  int empty_refusals;
  int middle_deletes;
  int deepest;

  int send_idle_pct;
  int recv_idle_pct;

  // Work out the result word of one request and advance the mirror.
  function automatic result_t serve_request(op_t op, word_t val);
    result_t r;
    int      mid;
    r = '0;
    if (op == OP_PUSH) begin
      if (mirror_count >= DEPTH) begin
        r.status = ST_FULL;
        full_refusals++;
      end else begin
        mirror_words[mirror_count] = val;
        mirror_count++;
      end
    end else if (mirror_count == 0) begin
      r.status = ST_EMPTY;
      empty_refusals++;
    end else if (op == OP_POP) begin
      mirror_count--;
      r.value = mirror_words[mirror_count];
    end else begin
      mid     = mirror_count / 2;
      r.value = mirror_words[mid];
      if (op == OP_DELETE_MID) begin
        // close the gap: everything above the middle drops by one place
        for (int i = mid; i + 1 < mirror_count; i++)
          mirror_words[i] = mirror_words[i + 1];
        mirror_count--;
        middle_deletes++;
      end
    end
    if (mirror_count > deepest)
      deepest = mirror_count;
    r.total = mirror_count[CNT_W-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Opening rows: empty-stack refusals, extremes of the value, a delete on a
  // single element, middle reads on odd and even counts, deletes on odd ones.
  // --------------------------------------------------------------------------
  localparam int OPENING_ROWS = 19;

  step_t opening [OPENING_ROWS] = '{
    '{OP_POP,        32'h0000_0000, 1'b1, '{32'h0000_0000, ST_EMPTY, 9'd0}},
    '{OP_READ_MID,   32'hAAAA_AAAA, 1'b1, '{32'h0000_0000, ST_EMPTY, 9'd0}},
    '{OP_DELETE_MID, 32'h5555_5555, 1'b1, '{32'h0000_0000, ST_EMPTY, 9'd0}},
    '{OP_PUSH,       32'h7FFF_FFFF, 1'b1, '{32'h0000_0000, ST_OK,    9'd1}},
    '{OP_READ_MID,   32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, ST_OK,    9'd1}},
    '{OP_DELETE_MID, 32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, ST_OK,    9'd0}},
    '{OP_PUSH,       32'h8000_0000, 1'b1, '{32'h0000_0000, ST_OK,    9'd1}},
    '{OP_PUSH,       32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, ST_OK,    9'd2}},
    '{OP_PUSH,       32'h0000_0000, 1'b1, '{32'h0000_0000, ST_OK,    9'd3}},
    '{OP_PUSH,       32'h0000_0001, 1'b1, '{32'h0000_0000, ST_OK,    9'd4}},
    '{OP_PUSH,       32'h5555_5555, 1'b1, '{32'h0000_0000, ST_OK,    9'd5}},
    '{OP_READ_MID,   32'hFFFF_FFFF, 1'b0, '0},
    '{OP_DELETE_MID, 32'h0000_0000, 1'b0, '0},
    '{OP_READ_MID,   32'h0000_0000, 1'b0, '0},
    '{OP_POP,        32'h0000_0000, 1'b0, '0},
    '{OP_DELETE_MID, 32'h0000_0000, 1'b0, '0},
    '{OP_POP,        32'h0000_0000, 1'b0, '0},
    '{OP_POP,        32'h0000_0000, 1'b0, '0},
    '{OP_POP,        32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, ST_EMPTY, 9'd0}}
  };

  // Offer one request word and hold it until taken. Entered and left just
  // after a falling edge; valid is left high for the next word to reuse.
  task automatic send_word(input op_t op, input word_t val,
                           input logic typed, input result_t want);
    result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.operation  = op;
    in_ch.push_value = val;
    do @(posedge clk); while (!in_ch.ready);
    predicted = serve_request(op, val);
    awaited_results.push_back(typed ? want : predicted);
    words_sent++;
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Sender: reset, opening rows, then random segments
  // --------------------------------------------------------------------------
  initial begin
    op_t   op;
    word_t val;
    mode_e mode;
    int    seg_left;
    int    random_sent;
    int    pick;

    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.operation  = OP_PUSH;
    in_ch.push_value = '0;
    mirror_count     = 0;
    words_sent       = 0;
    full_refusals    = 0;
    empty_refusals   = 0;
    middle_deletes   = 0;
    deepest          = 0;
    send_idle_pct    = 24;
    recv_idle_pct    = 53;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < OPENING_ROWS; i++)
      send_word(opening[i].op, opening[i].value, opening[i].typed, opening[i].want);

    // Open with a fill so the full case and the long hold-off meet a deep stack
    mode        = MODE_FILL;
    seg_left    = 1 << 30;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      // swap the idle pattern, then drop idling altogether
      if (random_sent == RANDOM_ITEMS / 3) begin
        send_idle_pct = 53;
        recv_idle_pct = 24;
      end else if (random_sent == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      if (seg_left <= 0) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          mode     = MODE_FILL;
          seg_left = 1 << 30;
        end else if (pick < 16) begin
          mode     = MODE_DRAIN;
          seg_left = 1 << 30;
        end else begin
          mode     = (pick < 45) ? MODE_GROW : (pick < 70) ? MODE_SHRINK : MODE_MIXED;
          seg_left = $urandom_range(50, 8);
        end
      end

      pick = $urandom_range(99);
      case (mode)
        MODE_FILL: begin
          op = OP_PUSH;
          // once full, knock on the lid a few more times and move on
          if (mirror_count >= DEPTH && seg_left > 4)
            seg_left = $urandom_range(3, 1) + 1;
        end
        MODE_DRAIN: begin
          op = (pick < 45) ? OP_POP : (pick < 80) ? OP_DELETE_MID : OP_READ_MID;
          if (mirror_count == 0 && seg_left > 4)
            seg_left = $urandom_range(3, 1) + 1;
        end
        MODE_GROW:   op = (pick < 70) ? OP_PUSH : op_t'($urandom_range(3, 1));
        MODE_SHRINK: op = (pick < 30) ? OP_PUSH : op_t'($urandom_range(3, 1));
        default:     op = op_t'($urandom_range(3, 0));
      endcase

      case ($urandom_range(15))
        0:       val = 32'h7FFF_FFFF;
        1:       val = 32'h8000_0000;
        2:       val = 32'h0000_0000;
        3:       val = 32'hFFFF_FFFF;
        default: val = $urandom;
      endcase

      send_word(op, val, 1'b0, '0);
      random_sent++;
      seg_left--;
    end

    in_ch.valid = 1'b0;

    // drain what is still in flight, then leave room for a stray word
    while (awaited_results.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d requests and %0d results; deepest stack %0d, %0d middle deletes,",
             words_sent, results_seen, deepest, middle_deletes);
    $display("  %0d pushes refused as full, %0d requests refused as empty.",
             full_refusals, empty_refusals);
    if (fail_count == 0) begin
      $display("stack_with_middle_access verification clean");
    end else begin
      $display("stack_with_middle_access verification failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: random back-pressure, plus one long hold-off so the result
  // register and the sequencer fill up and the input stalls.
  // --------------------------------------------------------------------------
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready = 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      out_ch.ready = 1'b0;
      hold_left    = HOLD_CYCLES - 1;
      hold_done    = 1'b1;
    end else begin
      out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Checker: every result word against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        $error("result word with nothing outstanding: value %0d status %0d total %0d",
               out_ch.out_value, out_ch.status, out_ch.element_total);
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        if (out_ch.out_value !== want.value) begin
          $error("out_value: expected %0d, got %0d",
                 $signed(want.value), out_ch.out_value);
          fail_count++;
        end
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          fail_count++;
        end
        if (out_ch.element_total !== want.total) begin
          $error("element_total: expected %0d, got %0d", want.total, out_ch.element_total);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: give up when no word has moved for too long
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no word accepted for %0d cycles, %0d results outstanding",
               STALL_LIMIT, awaited_results.size());
      $display("stack_with_middle_access verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ===== sim.f =====
hdl/stk_pkg.sv
hdl/stk_if.sv
hdl/stk_mem.sv
hdl/stack_with_middle_access.sv
test/tb.sv
